FILE: rtl/soa_pkg.sv
`timescale 1ns / 1ps
package soa_pkg;
  localparam int NumSlabs   = 16;
  localparam int MaxObjects = 256;
  localparam int SlotW      = $clog2(NumSlabs);
  localparam int IdxW       = $clog2(MaxObjects);
  localparam int NW         = IdxW + 1;
  localparam int TotW       = 13;
  localparam logic [TotW-1:0] TotalMax = 13'd8191;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_IGNORED   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LIST_UNUSED  = 2'd0,
    LIST_EMPTY   = 2'd1,
    LIST_PARTIAL = 2'd2,
    LIST_FULL    = 2'd3
  } list_e;

  typedef enum logic [1:0] {
    REG_NOBJ  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_FIRST = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PSCAN, S_BSCAN, S_ESCAN, S_USCAN, S_DIV, S_MUL, S_FREE_CHK, S_DONE
  } state_e;

  // Control from the sequencer to the shared divide / multiply unit.
  typedef struct packed {
    logic       start_div;
    logic       start_mul;
  } unit_ctl_t;
endpackage

FILE: rtl/soa_arith.sv
`timescale 1ns / 1ps
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module soa_arith (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  soa_pkg::unit_ctl_t     ctl_i,
  input  logic [12:0]            a_i,
  input  logic [12:0]            b_i,
  output logic                   done_o,
  output logic [12:0]            res_o
);
  import soa_pkg::*;

  logic [12:0] acc_q, acc_d, quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, mul_q, mul_d;
  logic [13:0] trial;

  always_comb begin
    acc_d  = acc_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    mul_d  = mul_q;
    trial  = {acc_q, quo_q[12]} - {1'b0, b_i};
    if (ctl_i.start_div || ctl_i.start_mul) begin
      busy_d = 1'b1;
      mul_d  = ctl_i.start_mul;
      acc_d  = '0;
      quo_d  = a_i;
      cnt_d  = 4'd13;
    end else if (busy_q) begin
      if (mul_q) begin
        // Multiplier bits come from quo_q MSB first.
        acc_d = {acc_q[11:0], 1'b0} + (quo_q[12] ? b_i : 13'd0);
        quo_d = {quo_q[11:0], 1'b0};
      end else begin
        if (!trial[13]) begin
          acc_d = trial[12:0];
          quo_d = {quo_q[11:0], 1'b1};
        end else begin
          acc_d = {acc_q[11:0], quo_q[12]};
          quo_d = {quo_q[11:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mul_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      mul_q  <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
  end

  assign done_o = busy_q && (cnt_q == 4'd1);
  assign res_o  = mul_q ? acc_d : quo_d;
endmodule

FILE: rtl/slab_object_allocator.sv
`timescale 1ns / 1ps
// Slab allocator over 16 page slabs of up to 256 objects each. A command is taken
// when start is high and busy is low; one result beat follows with done_o high for
// one cycle, and the receiver cannot stall it. busy stays high through the result
// beat, so the next command is taken in the cycle after it at the earliest. Latency,
// from the accepting edge to the edge that takes the result, is set by the slot scans
// (one slot per cycle), the bitmap search (eight bits per cycle) and the shared
// bit-serial multiply/divide unit: clear and no operation use none of these, a free
// rejected before the divide skips the unit, any other free uses the divide, and an
// allocate uses the scans, the bitmap search for a partial slab and the multiply. Each
// partial slab with no free object below a lowered object count adds a search and a rescan.
// Configuration goes through the APB port at 0x0, 0x4, 0x8.
module slab_object_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  slab_slot_i,
  input  logic [11:0] object_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  granted_slot_o,
  output logic [7:0]  granted_index_o,
  output logic [11:0] granted_offset_o,
  output logic [12:0] alloc_count_o,
  output logic [12:0] capacity_count_o
);
  import soa_pkg::*;

  logic [8:0]  nobj_q;
  logic [12:0] size_q;
  logic [11:0] first_q;
  logic        wr;
  logic [1:0]  ridx;
  logic        accept;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nobj_q  <= 9'd1;
      size_q  <= 13'd1;
      first_q <= '0;
    end else if (wr) begin
      case (reg_e'(ridx))
        REG_NOBJ:  nobj_q  <= pwdata[8:0];
        REG_SIZE:  size_q  <= pwdata[12:0];
        REG_FIRST: first_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(ridx))
      REG_NOBJ:  prdata = {23'd0, nobj_q};
      REG_SIZE:  prdata = {19'd0, size_q};
      REG_FIRST: prdata = {20'd0, first_q};
      default:   prdata = '0;
    endcase
  end

  logic [NW-1:0] n_eff;
  logic [12:0]   sz_eff;
  assign n_eff  = (nobj_q == 9'd0) ? NW'(1) : (nobj_q > 9'(MaxObjects)) ? NW'(MaxObjects)
                                   : NW'(nobj_q);
  assign sz_eff = (size_q == 13'd0) ? 13'd1 : size_q;

  // Slab state.
  logic [MaxObjects-1:0] bmp_q [NumSlabs];
  logic [NW-1:0]         fc_q  [NumSlabs];
  list_e                 lm_q  [NumSlabs];
  logic [15:0]           stp_q [NumSlabs];
  logic [15:0]           ctr_q;
  logic [TotW-1:0]       used_q, cap_q;

  state_e state_q, state_d;
  logic [1:0]        cmd_q;
  logic [SlotW-1:0]  sslot_q;
  logic [11:0]       soff_q;
  logic [SlotW:0]    scan_q, scan_d;
  logic              bfound_q, bfound_d;
  logic [SlotW-1:0]  best_q, best_d;
  logic [15:0]       bage_q, bage_d;
  logic [IdxW:0]     bidx_q, bidx_d;
  logic [SlotW-1:0]  gs_q, gs_d;
  logic [IdxW-1:0]   gi_q, gi_d;
  logic [1:0]        st_q, st_d;
  logic              done_q;

  assign accept = start && !busy;

  // Arithmetic unit.
  unit_ctl_t   uctl;
  logic [12:0] ua, ub, ures;
  logic        udone;
  logic [12:0] diff;
  assign diff = {1'b0, soff_q} - {1'b0, first_q};

  soa_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (uctl),
    .a_i    (ua),
    .b_i    (ub),
    .done_o (udone),
    .res_o  (ures)
  );

  // Per-cycle side-effect requests from the sequencer.
  logic            do_move;
  list_e           mv_list;
  logic [SlotW-1:0] mv_slot;
  logic            do_alloc_bit, do_new, do_free_bit, do_clear, inc_used, inc_cap;
  logic [IdxW-1:0] bit_idx;
  logic [SlotW-1:0] cur;
  logic [15:0]     age;
  logic [7:0]      oct;
  logic [IdxW:0]   hit_idx;
  logic            hit;
  logic [IdxW:0]   div_idx;

  assign cur = scan_q[SlotW-1:0];
  assign age = ctr_q - stp_q[cur];
  assign div_idx = (ures[12:IdxW+1] != '0) ? {(IdxW+1){1'b1}} : ures[IdxW:0];

  always_comb begin
    oct = '0;
    for (int k = 0; k < 8; k++) begin
      oct[k] = ~bmp_q[best_q][{bidx_q[IdxW-1:3], 3'(k)}];
    end
    hit = 1'b0;
    hit_idx = bidx_q;
    for (int k = 7; k >= 0; k--) begin
      if (oct[k] && ({bidx_q[IdxW:3], 3'(k)} < (IdxW+1)'(n_eff))) begin
        hit = 1'b1;
        hit_idx = {bidx_q[IdxW:3], 3'(k)};
      end
    end
  end

  always_comb begin
    state_d = state_q;  scan_d = scan_q;  bfound_d = bfound_q;  best_d = best_q;
    bage_d = bage_q;    bidx_d = bidx_q;  gs_d = gs_q;  gi_d = gi_q;  st_d = st_q;
    do_move = 1'b0; mv_list = LIST_FULL; mv_slot = best_q;
    do_alloc_bit = 1'b0; do_new = 1'b0; do_free_bit = 1'b0; do_clear = 1'b0;
    inc_used = 1'b0; inc_cap = 1'b0; bit_idx = gi_q;
    uctl = '0; ua = diff; ub = sz_eff;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d = '0; bfound_d = 1'b0; st_d = ST_OK; gs_d = '0; gi_d = '0;
          case (cmd_e'(cmd_i))
            CMD_ALLOC: state_d = S_PSCAN;
            CMD_FREE:  state_d = S_FREE_CHK;
            CMD_CLEAR: begin do_clear = 1'b1; state_d = S_DONE; end
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_PSCAN, S_ESCAN: begin
        if (scan_q[SlotW]) begin
          scan_d = '0; bfound_d = 1'b0;
          if (bfound_q) begin
            if (state_q == S_PSCAN) begin
              bidx_d = '0; state_d = S_BSCAN;
            end else begin
              gs_d = best_q; gi_d = '0; do_new = 1'b1; inc_used = 1'b1;
              state_d = S_MUL;
            end
          end else begin
            state_d = (state_q == S_PSCAN) ? S_ESCAN : S_USCAN;
          end
        end else begin
          if (lm_q[cur] == ((state_q == S_PSCAN) ? LIST_PARTIAL : LIST_EMPTY) &&
              (!bfound_q || age < bage_q)) begin
            bfound_d = 1'b1; best_d = cur; bage_d = age;
          end
          scan_d = scan_q + 1'b1;
        end
      end
      S_BSCAN: begin
        if (hit) begin
          gs_d = best_q; gi_d = hit_idx[IdxW-1:0]; bit_idx = hit_idx[IdxW-1:0];
          do_alloc_bit = 1'b1; inc_used = 1'b1;
          if (fc_q[best_q] <= NW'(1)) begin
            do_move = 1'b1; mv_list = LIST_FULL;
          end
          state_d = S_MUL;
        end else if (bidx_q + (IdxW+1)'(8) >= (IdxW+1)'(n_eff)) begin
          do_move = 1'b1; mv_list = LIST_FULL;
          scan_d = '0; state_d = S_PSCAN;
        end else begin
          bidx_d = bidx_q + (IdxW+1)'(8);
        end
      end
      S_USCAN: begin
        if (scan_q[SlotW]) begin
          st_d = ST_EXHAUSTED; state_d = S_DONE;
        end else if (lm_q[cur] == LIST_UNUSED) begin
          best_d = cur; gs_d = cur; gi_d = '0; do_new = 1'b1; mv_slot = cur;
          inc_used = 1'b1; inc_cap = 1'b1; state_d = S_MUL;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_MUL: begin
        if (!bfound_q) begin
          bfound_d = 1'b1; uctl.start_mul = 1'b1; ua = 13'(gi_q);
        end else if (udone) begin
          state_d = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if ((lm_q[sslot_q] != LIST_PARTIAL && lm_q[sslot_q] != LIST_FULL) ||
            soff_q < first_q) begin
          st_d = ST_IGNORED; state_d = S_DONE;
        end else begin
          uctl.start_div = 1'b1; state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (udone) begin
          bit_idx = div_idx[IdxW-1:0];
          if (div_idx >= (IdxW+1)'(n_eff) || !bmp_q[sslot_q][div_idx[IdxW-1:0]]) begin
            st_d = ST_IGNORED;
          end else begin
            do_free_bit = 1'b1;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [12:0] go_full;
  assign go_full = 13'(first_q) + ures;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; scan_q <= '0; bfound_q <= 1'b0; done_q <= 1'b0;
      ctr_q <= '0; used_q <= '0; cap_q <= '0; st_q <= ST_OK; gs_q <= '0; gi_q <= '0;
      granted_offset_o <= '0;
      for (int s = 0; s < NumSlabs; s++) begin
        bmp_q[s] <= '0; fc_q[s] <= '0; lm_q[s] <= LIST_UNUSED; stp_q[s] <= '0;
      end
    end else begin
      state_q <= state_d; scan_q <= scan_d; bfound_q <= bfound_d;
      st_q <= st_d; gs_q <= gs_d; gi_q <= gi_d;
      done_q <= (state_q == S_DONE);
      if (state_q == S_IDLE) granted_offset_o <= '0;
      if (state_q == S_MUL && bfound_q && udone) granted_offset_o <= go_full[11:0];
      if (do_clear) begin
        ctr_q <= '0; used_q <= '0; cap_q <= '0;
        for (int s = 0; s < NumSlabs; s++) begin
          bmp_q[s] <= '0; fc_q[s] <= '0; lm_q[s] <= LIST_UNUSED; stp_q[s] <= '0;
        end
      end
      if (inc_used && used_q != TotalMax) used_q <= used_q + 1'b1;
      if (inc_cap) begin
        cap_q <= (14'(cap_q) + 14'(n_eff) > 14'(TotalMax)) ? TotalMax
               : cap_q + TotW'(n_eff);
      end
      if (do_move) begin
        lm_q[mv_slot] <= mv_list; stp_q[mv_slot] <= ctr_q; ctr_q <= ctr_q + 1'b1;
      end
      if (do_alloc_bit) begin
        bmp_q[best_q][bit_idx] <= 1'b1;
        if (fc_q[best_q] != '0) fc_q[best_q] <= fc_q[best_q] - 1'b1;
      end
      if (do_new) begin
        bmp_q[mv_slot] <= {{(MaxObjects-1){1'b0}}, 1'b1};
        fc_q[mv_slot]  <= n_eff - 1'b1;
        lm_q[mv_slot]  <= (n_eff > NW'(1)) ? LIST_PARTIAL : LIST_FULL;
        stp_q[mv_slot] <= ctr_q; ctr_q <= ctr_q + 1'b1;
      end
      if (do_free_bit) begin
        if (used_q != '0) used_q <= used_q - 1'b1;
        if (fc_q[sslot_q] + 1'b1 >= n_eff) begin
          bmp_q[sslot_q] <= '0;
          fc_q[sslot_q]  <= n_eff;
          lm_q[sslot_q]  <= LIST_EMPTY;
          stp_q[sslot_q] <= ctr_q; ctr_q <= ctr_q + 1'b1;
        end else begin
          bmp_q[sslot_q][bit_idx] <= 1'b0;
          fc_q[sslot_q] <= fc_q[sslot_q] + 1'b1;
          if (lm_q[sslot_q] == LIST_FULL) begin
            lm_q[sslot_q] <= LIST_PARTIAL;
            stp_q[sslot_q] <= ctr_q; ctr_q <= ctr_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i; sslot_q <= slab_slot_i; soff_q <= object_offset_i;
    end
    best_q <= best_d; bage_q <= bage_d; bidx_q <= bidx_d;
  end

  assign busy             = (state_q != S_IDLE) || done_q;
  assign done_o           = done_q;
  assign status_o         = st_q;
  assign granted_slot_o   = gs_q;
  assign granted_index_o  = gi_q;
  assign alloc_count_o    = used_q;
  assign capacity_count_o = cap_q;

  // Sequencer and result beat must stay consistent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result beat while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat repeated");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> granted_slot_o == '0 && granted_index_o == '0)
    else $error("grant fields set on failed command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && cmd_q == CMD_CLEAR |-> alloc_count_o == '0 && capacity_count_o == '0)
    else $error("clear left counters");
endmodule
